>>> rtl/triangle_face_normal_macros.svh
// Assertion macros used by the file that checks behavior.
`ifndef TRIANGLE_FACE_NORMAL_MACROS_SVH
`define TRIANGLE_FACE_NORMAL_MACROS_SVH

// A condition that must hold in the same cycle as its trigger.
`define TFN_ASSERT_IMPLY(label, clk, rst_n, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error("tfn check failed");

// A condition that must hold in the cycle after its trigger.
`define TFN_ASSERT_NEXT(label, clk, rst_n, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("tfn check failed");

`endif

>>> rtl/tfn_pkg.sv
package tfn_pkg;

    // Field widths.
    localparam int CW  = 16;              // corner coordinate
    localparam int F   = 14;              // fraction bits of the normal
    localparam int OW  = F + 2;           // normal component
    localparam int NL  = 3;               // vector lanes

    // Internal widths.
    localparam int EW  = CW + 1;          // edge component
    localparam int PW  = 2 * EW;          // edge product
    localparam int CXW = PW + 1;          // cross product component, signed
    localparam int MW  = PW;              // cross product magnitude
    localparam int HW  = (MW + 1) / 2;    // low half of magnitude for squaring
    localparam int QDW = 2 * MW;          // square of a magnitude
    localparam int SW  = QDW + 2;         // sum of squares
    localparam int QW  = 2 * F + 3;       // quotient of a^2 * 2^(2F+2) / s
    localparam int QSTEPS = (QW + 1) / 2; // square root steps
    localparam int RTW = QSTEPS;          // root width
    localparam int RMW = RTW + 4;         // square root remainder
    localparam int ONE = 1 << F;

    // Front pipeline depth and queue depth.
    localparam int NFS = 6;
    localparam int QD  = 4;
    localparam int QAW = $clog2(QD);

    // Classified triangle handed from the front to the back.
    typedef struct packed {
        logic [SW-1:0]           sum_sq;
        logic [NL-1:0][QDW-1:0]  sq;
        logic [NL-1:0]           neg;
        logic                    plane;
    } t_item;

endpackage

>>> rtl/tfn_if.sv
// Triangle channel: three corners per transaction.
interface tfn_tri_if;
    logic valid;
    logic ready;
    logic signed [tfn_pkg::CW-1:0] first_x;
    logic signed [tfn_pkg::CW-1:0] first_y;
    logic signed [tfn_pkg::CW-1:0] first_z;
    logic signed [tfn_pkg::CW-1:0] second_x;
    logic signed [tfn_pkg::CW-1:0] second_y;
    logic signed [tfn_pkg::CW-1:0] second_z;
    logic signed [tfn_pkg::CW-1:0] third_x;
    logic signed [tfn_pkg::CW-1:0] third_y;
    logic signed [tfn_pkg::CW-1:0] third_z;

    modport source (
        output valid, first_x, first_y, first_z, second_x, second_y, second_z,
               third_x, third_y, third_z,
        input  ready
    );
    modport sink (
        input  valid, first_x, first_y, first_z, second_x, second_y, second_z,
               third_x, third_y, third_z,
        output ready
    );
endinterface

// Normal channel: one unit normal per transaction.
interface tfn_norm_if;
    logic valid;
    logic ready;
    logic signed [tfn_pkg::OW-1:0] normal_x;
    logic signed [tfn_pkg::OW-1:0] normal_y;
    logic signed [tfn_pkg::OW-1:0] normal_z;
    logic                          valid_res;

    modport source (
        output valid, normal_x, normal_y, normal_z, valid_res,
        input  ready
    );
    modport sink (
        input  valid, normal_x, normal_y, normal_z, valid_res,
        output ready
    );
endinterface

>>> rtl/tfn_front.sv
// Front part: edges, cross product, squares and their sum, in six stages.
module tfn_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    tfn_tri_if.sink            i_tri,
    input  logic               i_room,
    output logic               o_valid,
    output tfn_pkg::t_item     o_item
);

    logic                             w_en;
    logic [tfn_pkg::NFS-1:0]          r_v;

    logic signed [tfn_pkg::EW-1:0]    r_a [tfn_pkg::NL];
    logic signed [tfn_pkg::EW-1:0]    r_b [tfn_pkg::NL];
    logic signed [tfn_pkg::PW-1:0]    r_p [2*tfn_pkg::NL];
    logic [tfn_pkg::MW-1:0]           r_mag [tfn_pkg::NL];
    logic [2*(tfn_pkg::MW-tfn_pkg::HW)-1:0] r_hh [tfn_pkg::NL];
    logic [tfn_pkg::MW-1:0]           r_hl [tfn_pkg::NL];
    logic [2*tfn_pkg::HW-1:0]         r_ll [tfn_pkg::NL];
    logic [tfn_pkg::QDW-1:0]          r_sq5 [tfn_pkg::NL];
    logic [tfn_pkg::QDW-1:0]          r_sq6 [tfn_pkg::NL];
    logic [tfn_pkg::SW-1:0]           r_s;
    logic [tfn_pkg::NL-1:0]           r_neg3, r_neg4, r_neg5, r_neg6;
    logic                             r_pl3, r_pl4, r_pl5, r_pl6;

    logic signed [tfn_pkg::CXW-1:0]   w_c [tfn_pkg::NL];
    logic [tfn_pkg::CXW-1:0]          w_abs [tfn_pkg::NL];

    // The whole front moves unless its last stage holds a transaction the queue cannot take.
    assign w_en        = !r_v[tfn_pkg::NFS-1] || i_room;
    assign i_tri.ready = w_en;

    // Valid bits of the stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_en) begin
            r_v <= {r_v[tfn_pkg::NFS-2:0], i_tri.valid};
        end
    end

    // Cross product components and their magnitudes.
    always_comb begin
        w_c[0] = {r_p[0][tfn_pkg::PW-1], r_p[0]} - {r_p[1][tfn_pkg::PW-1], r_p[1]};
        w_c[1] = {r_p[2][tfn_pkg::PW-1], r_p[2]} - {r_p[3][tfn_pkg::PW-1], r_p[3]};
        w_c[2] = {r_p[4][tfn_pkg::PW-1], r_p[4]} - {r_p[5][tfn_pkg::PW-1], r_p[5]};
        for (int l = 0; l < tfn_pkg::NL; l++) begin
            w_abs[l] = w_c[l][tfn_pkg::CXW-1] ? -w_c[l] : w_c[l];
        end
    end

    // Datapath stages.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            // Stage 1: edges p2 - p1 and p3 - p1.
            r_a[0] <= {i_tri.second_x[tfn_pkg::CW-1], i_tri.second_x}
                    - {i_tri.first_x[tfn_pkg::CW-1], i_tri.first_x};
            r_a[1] <= {i_tri.second_y[tfn_pkg::CW-1], i_tri.second_y}
                    - {i_tri.first_y[tfn_pkg::CW-1], i_tri.first_y};
            r_a[2] <= {i_tri.second_z[tfn_pkg::CW-1], i_tri.second_z}
                    - {i_tri.first_z[tfn_pkg::CW-1], i_tri.first_z};
            r_b[0] <= {i_tri.third_x[tfn_pkg::CW-1], i_tri.third_x}
                    - {i_tri.first_x[tfn_pkg::CW-1], i_tri.first_x};
            r_b[1] <= {i_tri.third_y[tfn_pkg::CW-1], i_tri.third_y}
                    - {i_tri.first_y[tfn_pkg::CW-1], i_tri.first_y};
            r_b[2] <= {i_tri.third_z[tfn_pkg::CW-1], i_tri.third_z}
                    - {i_tri.first_z[tfn_pkg::CW-1], i_tri.first_z};

            // Stage 2: the six products of the cross product.
            r_p[0] <= r_a[1] * r_b[2];
            r_p[1] <= r_a[2] * r_b[1];
            r_p[2] <= r_a[2] * r_b[0];
            r_p[3] <= r_a[0] * r_b[2];
            r_p[4] <= r_a[0] * r_b[1];
            r_p[5] <= r_a[1] * r_b[0];

            // Stage 3: components as sign and magnitude; a zero vector is collinear.
            for (int l = 0; l < tfn_pkg::NL; l++) begin
                r_mag[l]  <= w_abs[l][tfn_pkg::MW-1:0];
                r_neg3[l] <= w_c[l][tfn_pkg::CXW-1];
            end
            r_pl3 <= (w_c[0] != '0) || (w_c[1] != '0) || (w_c[2] != '0);

            // Stage 4: partial products of each square.
            for (int l = 0; l < tfn_pkg::NL; l++) begin
                r_hh[l] <= r_mag[l][tfn_pkg::MW-1:tfn_pkg::HW]
                         * r_mag[l][tfn_pkg::MW-1:tfn_pkg::HW];
                r_hl[l] <= r_mag[l][tfn_pkg::MW-1:tfn_pkg::HW] * r_mag[l][tfn_pkg::HW-1:0];
                r_ll[l] <= r_mag[l][tfn_pkg::HW-1:0] * r_mag[l][tfn_pkg::HW-1:0];
            end
            r_neg4 <= r_neg3;
            r_pl4  <= r_pl3;

            // Stage 5: squares.
            for (int l = 0; l < tfn_pkg::NL; l++) begin
                r_sq5[l] <= (tfn_pkg::QDW'(r_hh[l]) << (2*tfn_pkg::HW))
                          + (tfn_pkg::QDW'(r_hl[l]) << (tfn_pkg::HW+1))
                          + tfn_pkg::QDW'(r_ll[l]);
            end
            r_neg5 <= r_neg4;
            r_pl5  <= r_pl4;

            // Stage 6: squared length.
            r_s <= tfn_pkg::SW'(r_sq5[0]) + tfn_pkg::SW'(r_sq5[1]) + tfn_pkg::SW'(r_sq5[2]);
            for (int l = 0; l < tfn_pkg::NL; l++) begin
                r_sq6[l] <= r_sq5[l];
            end
            r_neg6 <= r_neg5;
            r_pl6  <= r_pl5;
        end
    end

    assign o_valid       = r_v[tfn_pkg::NFS-1];
    assign o_item.sum_sq = r_s;
    assign o_item.sq[0]  = r_sq6[0];
    assign o_item.sq[1]  = r_sq6[1];
    assign o_item.sq[2]  = r_sq6[2];
    assign o_item.neg    = r_neg6;
    assign o_item.plane  = r_pl6;

endmodule

>>> rtl/tfn_fifo.sv
// Short queue between the front and the back.
module tfn_fifo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  tfn_pkg::t_item     i_data,
    input  logic               i_pop,
    output tfn_pkg::t_item     o_data,
    output logic               o_empty,
    output logic               o_full
);

    tfn_pkg::t_item            r_mem [tfn_pkg::QD];
    logic [tfn_pkg::QAW-1:0]   r_wr, r_rd;
    logic [tfn_pkg::QAW:0]     r_cnt;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == (tfn_pkg::QAW+1)'(tfn_pkg::QD));
    assign o_data  = r_mem[r_rd];

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

>>> rtl/tfn_back.sv
// Back part: a^2 * 2^(2F+2) / s by restoring division, one quotient bit a stage,
// then the integer square root two bits a stage, then rounding and sign.
module tfn_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  tfn_pkg::t_item     i_item,
    output logic               o_take,
    tfn_norm_if.source         o_norm
);

    localparam int NST = tfn_pkg::QW + tfn_pkg::QSTEPS;

    logic                          w_en;

    logic                          w_v   [NST+1];
    logic [tfn_pkg::NL-1:0]        w_neg [NST+1];
    logic                          w_pl  [NST+1];

    logic [tfn_pkg::SW-1:0]        w_rem [tfn_pkg::QW][tfn_pkg::NL];
    logic [tfn_pkg::SW-1:0]        w_s   [tfn_pkg::QW];
    logic [tfn_pkg::QW-1:0]        w_q   [tfn_pkg::QW+1][tfn_pkg::NL];

    logic [2*tfn_pkg::QSTEPS-1:0]  w_qs   [tfn_pkg::QSTEPS][tfn_pkg::NL];
    logic [tfn_pkg::RMW-1:0]       w_srem [tfn_pkg::QSTEPS][tfn_pkg::NL];
    logic [tfn_pkg::RTW-1:0]       w_root [tfn_pkg::QSTEPS+1][tfn_pkg::NL];

    logic                          r_ov;
    logic                          r_ores;
    logic signed [tfn_pkg::OW-1:0] r_on [tfn_pkg::NL];

    // The pipeline moves whenever the output register is free or being emptied.
    assign w_en   = !r_ov || o_norm.ready;
    assign o_take = w_en && i_valid;

    // Stage zero is the head of the queue.
    assign w_v[0]   = i_valid;
    assign w_neg[0] = i_item.neg;
    assign w_pl[0]  = i_item.plane;
    assign w_s[0]   = i_item.sum_sq;
    for (genvar l = 0; l < tfn_pkg::NL; l++) begin : g_in
        assign w_rem[0][l] = tfn_pkg::SW'(i_item.sq[l]);
        assign w_q[0][l]   = '0;
    end

    // Control carried along every stage.
    for (genvar g = 0; g < NST; g++) begin : g_ctl
        logic                   r_v;
        logic [tfn_pkg::NL-1:0] r_neg;
        logic                   r_pl;
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (w_en) begin
                r_v <= w_v[g];
            end
        end
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_neg <= w_neg[g];
                r_pl  <= w_pl[g];
            end
        end
        assign w_v[g+1]   = r_v;
        assign w_neg[g+1] = r_neg;
        assign w_pl[g+1]  = r_pl;
    end

    // Division stages: one quotient bit per lane each.
    for (genvar g = 0; g < tfn_pkg::QW; g++) begin : g_div
        for (genvar l = 0; l < tfn_pkg::NL; l++) begin : g_lane
            logic [tfn_pkg::SW:0]   w_d;
            logic [tfn_pkg::SW:0]   w_diff;
            logic                   w_ge;
            logic [tfn_pkg::QW-1:0] r_q;

            assign w_d    = (g == 0) ? {1'b0, w_rem[g][l]} : {w_rem[g][l], 1'b0};
            assign w_diff = w_d - {1'b0, w_s[g]};
            assign w_ge   = (w_d >= {1'b0, w_s[g]});

            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r_q <= {w_q[g][l][tfn_pkg::QW-2:0], w_ge};
                end
            end
            assign w_q[g+1][l] = r_q;

            if (g < tfn_pkg::QW - 1) begin : g_rem
                logic [tfn_pkg::SW-1:0] r_rem;
                always_ff @(posedge i_clk) begin
                    if (w_en) begin
                        r_rem <= w_ge ? w_diff[tfn_pkg::SW-1:0] : w_d[tfn_pkg::SW-1:0];
                    end
                end
                assign w_rem[g+1][l] = r_rem;
            end
        end
        if (g < tfn_pkg::QW - 1) begin : g_sum
            logic [tfn_pkg::SW-1:0] r_s;
            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r_s <= w_s[g];
                end
            end
            assign w_s[g+1] = r_s;
        end
    end

    // Square root input is the quotient.
    for (genvar l = 0; l < tfn_pkg::NL; l++) begin : g_sqin
        assign w_qs[0][l]   = (2*tfn_pkg::QSTEPS)'(w_q[tfn_pkg::QW][l]);
        assign w_srem[0][l] = '0;
        assign w_root[0][l] = '0;
    end

    // Square root stages: one root bit per lane each.
    for (genvar j = 0; j < tfn_pkg::QSTEPS; j++) begin : g_sqrt
        for (genvar l = 0; l < tfn_pkg::NL; l++) begin : g_lane
            logic [tfn_pkg::RMW-1:0] w_nr;
            logic [tfn_pkg::RMW-1:0] w_trial;
            logic                    w_ge;
            logic [tfn_pkg::RTW-1:0] r_root;

            assign w_nr    = {w_srem[j][l][tfn_pkg::RMW-3:0],
                              w_qs[j][l][2*tfn_pkg::QSTEPS-1 -: 2]};
            assign w_trial = tfn_pkg::RMW'({w_root[j][l], 2'b01});
            assign w_ge    = (w_nr >= w_trial);

            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r_root <= {w_root[j][l][tfn_pkg::RTW-2:0], w_ge};
                end
            end
            assign w_root[j+1][l] = r_root;

            if (j < tfn_pkg::QSTEPS - 1) begin : g_rem
                logic [tfn_pkg::RMW-1:0]         r_srem;
                logic [2*tfn_pkg::QSTEPS-1:0]    r_qs;
                always_ff @(posedge i_clk) begin
                    if (w_en) begin
                        r_srem <= w_ge ? (w_nr - w_trial) : w_nr;
                        r_qs   <= {w_qs[j][l][2*tfn_pkg::QSTEPS-3:0], 2'b00};
                    end
                end
                assign w_srem[j+1][l] = r_srem;
                assign w_qs[j+1][l]   = r_qs;
            end
        end
    end

    // Output register: largest odd u with u*u <= quotient gives t = (root + 1) / 2.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_en) begin
            r_ov <= w_v[NST];
        end
    end

    always_ff @(posedge i_clk) begin
        logic [tfn_pkg::RTW:0]  v_sum;
        logic [tfn_pkg::OW-1:0] v_t;
        if (w_en) begin
            r_ores <= w_pl[NST];
            for (int l = 0; l < tfn_pkg::NL; l++) begin
                v_sum = {1'b0, w_root[tfn_pkg::QSTEPS][l]} + 1'b1;
                v_t   = tfn_pkg::OW'(v_sum >> 1);
                if (!w_pl[NST]) begin
                    r_on[l] <= '0;
                end else if (w_neg[NST][l]) begin
                    r_on[l] <= -v_t;
                end else begin
                    r_on[l] <= v_t;
                end
            end
        end
    end

    assign o_norm.valid     = r_ov;
    assign o_norm.valid_res = r_ores;
    assign o_norm.normal_x  = r_on[0];
    assign o_norm.normal_y  = r_on[1];
    assign o_norm.normal_z  = r_on[2];

endmodule

>>> rtl/triangle_face_normal.sv
// Channel   Direction  Transaction
// i_tri     in         three corners, 9 x 16-bit signed coordinates
// o_norm    out        unit normal, 3 x 16-bit signed Q1.14, plus valid_res
//
// One triangle is accepted per cycle while i_tri.ready is high; the path runs through 6 front
// stages, the queue, 31 division stages, 16 square root stages and the output register.
// The divider and square root run one bit per pipeline stage, which sets the depth.
// Reset is synchronous and active low; it clears valid bits and the queue counters.
// A stall at o_norm holds the back pipeline; the four-entry queue lets the front keep
// accepting until it fills; i_tri.ready falls when it is full and the last front stage is valid.
`include "triangle_face_normal_macros.svh"

module triangle_face_normal (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tfn_tri_if.sink     i_tri,
    tfn_norm_if.source  o_norm
);

    logic               w_fvalid;
    tfn_pkg::t_item     w_fitem;
    tfn_pkg::t_item     w_qitem;
    logic               w_empty;
    logic               w_full;
    logic               w_push;
    logic               w_pop;
    logic               w_norm_zero;
    logic               w_queue_ok;

    // Front part.
    tfn_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tri   (i_tri),
        .i_room  (!w_full),
        .o_valid (w_fvalid),
        .o_item  (w_fitem)
    );

    assign w_push = w_fvalid && !w_full;

    // Queue between the parts.
    tfn_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_fitem),
        .i_pop   (w_pop),
        .o_data  (w_qitem),
        .o_empty (w_empty),
        .o_full  (w_full)
    );

    // Back part.
    tfn_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (!w_empty),
        .i_item  (w_qitem),
        .o_take  (w_pop),
        .o_norm  (o_norm)
    );

    // Conditions checked below.
    assign w_norm_zero = (o_norm.normal_x == '0) && (o_norm.normal_y == '0)
                      && (o_norm.normal_z == '0);
    assign w_queue_ok  = !i_tri.ready && !(w_pop && w_empty);

    // Collinear corners give a zero normal.
    `TFN_ASSERT_IMPLY(a_zero_when_flat, i_clk, i_rst_n, o_norm.valid && !o_norm.valid_res, w_norm_zero)

    // A plane always gives a nonzero normal.
    `TFN_ASSERT_IMPLY(a_nonzero_plane, i_clk, i_rst_n, o_norm.valid && o_norm.valid_res, !w_norm_zero)

    // A full queue with a valid last front stage stops the front and sees no pop while empty.
    `TFN_ASSERT_IMPLY(a_queue_bounds, i_clk, i_rst_n, w_full && w_fvalid, w_queue_ok)

endmodule
